@@ src/itr_pkg.sv @@
// Shared constants, types and helper functions for the radix text converter.
// No dependencies; every other source file except itr_ram imports this package.
package itr_pkg;

  // Width of the integer that is converted.
  localparam int VALUE_WIDTH = 32;
  localparam int RADIX_WIDTH = 6;
  localparam int CHAR_WIDTH  = 7;

  // The divider produces this many quotient bits in each cycle in which it steps.
  localparam int STEP_BITS      = 8;
  localparam int DIV_CYCLES     = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int WORK_WIDTH     = DIV_CYCLES * STEP_BITS;
  localparam int STEP_CNT_WIDTH = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // Radix 2 gives the longest text: one character for each value bit.
  localparam int DIGIT_DEPTH = VALUE_WIDTH;
  localparam int ADDR_WIDTH  = $clog2(DIGIT_DEPTH);

  localparam int RADIX_MIN     = 2;
  localparam int RADIX_MAX     = 36;
  localparam int RADIX_DEC     = 10;
  localparam int DIGIT_MAX_DEC = 9;

  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_WIDTH-1:0] CHAR_A     = 7'h61;
  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 7'h2d;
  localparam logic [CHAR_WIDTH-1:0] CHAR_NONE  = 7'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIV,
    ST_STORE,
    ST_SIGN,
    ST_FETCH,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    EMIT_SINGLE,
    EMIT_SIGN,
    EMIT_DIGIT
  } emit_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      div_step;
    logic      store;
    logic      idx_dec;
    emit_sel_t emit_sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bad;
    logic zero;
    logic neg;
    logic div_last;
    logic quo_zero;
    logic idx_zero;
  } status_t;

  // Maps a digit value to its lower-case ASCII character.
  function automatic logic [CHAR_WIDTH-1:0] digit_to_char(input logic [RADIX_WIDTH-1:0] d);
    logic [CHAR_WIDTH-1:0] d_ext;
    d_ext = CHAR_WIDTH'(d);
    if (d_ext > CHAR_WIDTH'(DIGIT_MAX_DEC)) begin
      return CHAR_A + d_ext - CHAR_WIDTH'(RADIX_DEC);
    end
    return CHAR_ZERO + d_ext;
  endfunction

endpackage

@@ src/itr_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module itr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/itr_dp.sv @@
// Datapath of the radix text converter: magnitude register, radix divider,
// digit store and result selection. Depends on itr_pkg and itr_ram.
module itr_dp import itr_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  cmd_t                          cmd,
  output status_t                       status,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic [RADIX_WIDTH-1:0]        radix,
  output logic [CHAR_WIDTH-1:0]         digit_char,
  output logic                          is_last,
  output logic                          nonzero,
  output logic                          bad_radix
);

  logic [WORK_WIDTH-1:0]     work;
  logic [WORK_WIDTH-1:0]     work_step;
  logic [RADIX_WIDTH-1:0]    rem;
  logic [RADIX_WIDTH-1:0]    rem_step;
  logic [RADIX_WIDTH-1:0]    base;
  logic [STEP_CNT_WIDTH-1:0] step;
  logic [ADDR_WIDTH-1:0]     count;
  logic [ADDR_WIDTH-1:0]     idx;
  logic                      bad_flag;
  logic                      nz_flag;
  logic                      neg_flag;
  logic [VALUE_WIDTH-1:0]    bits;
  logic [VALUE_WIDTH-1:0]    mag;
  logic                      in_bad;
  logic                      in_neg;
  logic [CHAR_WIDTH-1:0]     rdata;

  // Input decode for the load of a new transaction.
  assign bits   = VALUE_WIDTH'(value);
  assign in_bad = (radix < RADIX_WIDTH'(RADIX_MIN)) || (radix > RADIX_WIDTH'(RADIX_MAX));
  assign in_neg = (radix == RADIX_WIDTH'(RADIX_DEC)) && bits[VALUE_WIDTH-1];
  assign mag    = in_neg ? (~bits + VALUE_WIDTH'(1)) : bits;

  // Restoring division, several quotient bits per cycle. The dividend
  // shifts out at the top while quotient bits shift in at the bottom.
  always_comb begin
    logic [RADIX_WIDTH-1:0] r;
    logic [WORK_WIDTH-1:0]  w;
    logic [RADIX_WIDTH:0]   t;
    r = rem;
    w = work;
    t = '0;
    for (int j = 0; j < STEP_BITS; j++) begin
      t = {r, w[WORK_WIDTH-1]};
      w = {w[WORK_WIDTH-2:0], 1'b0};
      if (t >= {1'b0, base}) begin
        t = t - {1'b0, base};
        w[0] = 1'b1;
      end
      r = t[RADIX_WIDTH-1:0];
    end
    rem_step  = r;
    work_step = w;
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= '0;
      count    <= '0;
      idx      <= '0;
      bad_flag <= 1'b0;
      nz_flag  <= 1'b0;
      neg_flag <= 1'b0;
      rem      <= '0;
    end else begin
      if (cmd.load) begin
        work     <= WORK_WIDTH'(mag);
        base     <= radix;
        rem      <= '0;
        step     <= '0;
        count    <= '0;
        bad_flag <= in_bad;
        nz_flag  <= (bits != '0);
        neg_flag <= in_neg;
      end
      if (cmd.div_step) begin
        work <= work_step;
        rem  <= rem_step;
        step <= step + STEP_CNT_WIDTH'(1);
      end
      if (cmd.store) begin
        count <= count + ADDR_WIDTH'(1);
        idx   <= count;
        rem   <= '0;
        step  <= '0;
      end
      if (cmd.idx_dec) begin
        idx <= idx - ADDR_WIDTH'(1);
      end
    end
  end

  // Digit store, least significant character first.
  itr_ram #(
    .WIDTH(CHAR_WIDTH),
    .DEPTH(DIGIT_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.store),
    .waddr(count),
    .wdata(digit_to_char(rem)),
    .raddr(idx),
    .rdata(rdata)
  );

  // Status toward the controller.
  always_comb begin
    status.bad      = bad_flag;
    status.zero     = !nz_flag;
    status.neg      = neg_flag;
    status.div_last = (step == STEP_CNT_WIDTH'(DIV_CYCLES - 1));
    status.quo_zero = (work == '0);
    status.idx_zero = (idx == '0);
  end

  // Result field selection.
  always_comb begin
    case (cmd.emit_sel)
      EMIT_SINGLE: begin
        digit_char = bad_flag ? CHAR_NONE : CHAR_ZERO;
        is_last    = 1'b1;
        nonzero    = nz_flag;
        bad_radix  = bad_flag;
      end
      EMIT_SIGN: begin
        digit_char = CHAR_MINUS;
        is_last    = 1'b0;
        nonzero    = 1'b1;
        bad_radix  = 1'b0;
      end
      EMIT_DIGIT: begin
        digit_char = rdata;
        is_last    = (idx == '0);
        nonzero    = 1'b1;
        bad_radix  = 1'b0;
      end
      default: begin
        digit_char = CHAR_NONE;
        is_last    = 1'b0;
        nonzero    = 1'b0;
        bad_radix  = 1'b0;
      end
    endcase
  end

endmodule

@@ src/itr_ctrl.sv @@
// Controller state machine of the radix text converter.
// Depends on itr_pkg; drives the datapath through cmd_t and reads status_t.
module itr_ctrl import itr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  output logic    strobe,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_next = (status.bad || status.zero) ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        if (status.div_last) state_next = ST_STORE;
      end
      ST_STORE: begin
        if (!status.quo_zero) begin
          state_next = ST_DIV;
        end else begin
          state_next = status.neg ? ST_SIGN : ST_FETCH;
        end
      end
      ST_SIGN:  state_next = ST_OUT;
      ST_FETCH: state_next = ST_OUT;
      ST_OUT: begin
        state_next = status.idx_zero ? ST_IDLE : ST_FETCH;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    busy         = (state != ST_IDLE);
    strobe       = 1'b0;
    cmd.load     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.store    = 1'b0;
    cmd.idx_dec  = 1'b0;
    cmd.emit_sel = EMIT_DIGIT;
    case (state)
      ST_IDLE: cmd.load = start;
      ST_DECIDE: begin
        strobe       = status.bad || status.zero;
        cmd.emit_sel = EMIT_SINGLE;
      end
      ST_DIV:   cmd.div_step = 1'b1;
      ST_STORE: cmd.store = 1'b1;
      ST_SIGN: begin
        strobe       = 1'b1;
        cmd.emit_sel = EMIT_SIGN;
      end
      ST_FETCH: cmd.emit_sel = EMIT_DIGIT;
      ST_OUT: begin
        strobe       = 1'b1;
        cmd.idx_dec  = 1'b1;
        cmd.emit_sel = EMIT_DIGIT;
      end
      default: cmd.emit_sel = EMIT_DIGIT;
    endcase
  end

endmodule

@@ src/integer_to_radix_text.sv @@
// Top level of the radix text converter: controller and datapath.
// Depends on itr_pkg, itr_ctrl and itr_dp.
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+-----------------------------------------
//   command  | start in, busy out | value[31:0] signed, radix[5:0]
//   result   | strobe out         | digit_char[6:0], is_last, nonzero,
//            |                    | bad_radix
//
// A transaction is taken when start is high and busy is low. A bad radix or a
// zero value gives its single result in the cycle after it is taken. Otherwise
// each digit is computed by divider steps of 8 quotient bits each and then
// stored, and each character is then read back through the registered digit
// store read port, in a fetch state and then an output state. Reset is
// synchronous and returns to idle. Results cannot be stalled; each is shown
// for exactly one cycle with strobe.
module integer_to_radix_text import itr_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic [RADIX_WIDTH-1:0]        radix,
  output logic                          strobe,
  output logic [CHAR_WIDTH-1:0]         digit_char,
  output logic                          is_last,
  output logic                          nonzero,
  output logic                          bad_radix
);

  cmd_t    cmd;
  status_t status;

  // Sequencing.
  itr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .strobe(strobe),
    .status(status),
    .cmd   (cmd)
  );

  // Division, digit storage and result fields.
  itr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .value     (value),
    .radix     (radix),
    .digit_char(digit_char),
    .is_last   (is_last),
    .nonzero   (nonzero),
    .bad_radix (bad_radix)
  );

endmodule

@@ src/itr_checker.sv @@
// Port-level checks of the radix text converter, bound to the top level.
// Depends on itr_pkg and integer_to_radix_text.
module itr_checker import itr_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  strobe,
  input logic [CHAR_WIDTH-1:0] digit_char,
  input logic                  is_last,
  input logic                  nonzero,
  input logic                  bad_radix
);

  // A result only appears inside a transaction.
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("result outside a transaction");

  // An accepted transaction makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted transaction not started");

  // The last result ends the transaction.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && is_last) |=> !busy) else $error("busy after last result");

  // A bad radix gives a single result.
  a_bad_single: assert property (@(posedge clk) disable iff (rst)
    (strobe && bad_radix) |-> (is_last && digit_char == CHAR_NONE))
    else $error("bad radix result malformed");

  // A zero value gives a single '0'.
  a_zero_single: assert property (@(posedge clk) disable iff (rst)
    (strobe && !nonzero && !bad_radix) |-> (is_last && digit_char == CHAR_ZERO))
    else $error("zero value result malformed");

endmodule

bind integer_to_radix_text itr_checker u_itr_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .strobe    (strobe),
  .digit_char(digit_char),
  .is_last   (is_last),
  .nonzero   (nonzero),
  .bad_radix (bad_radix)
);
